@@ rtl/nrga_pkg.sv @@
// shared types and constants for the nearest resize gradient accumulator
// register map, item codes, config bundle and pipeline control struct
// no dependencies
package nrga_pkg;

  localparam int unsigned PADDR_W = 5;

  // register indexes, paddr[4:2]
  localparam logic [2:0] REG_SRC_ROWS  = 3'd0;
  localparam logic [2:0] REG_SRC_COLS  = 3'd1;
  localparam logic [2:0] REG_ROW_SCALE = 3'd2;
  localparam logic [2:0] REG_COL_SCALE = 3'd3;
  localparam logic [2:0] REG_ALIGN     = 3'd4;

  localparam logic [6:0]  RST_SRC_ROWS  = 7'd64;
  localparam logic [6:0]  RST_SRC_COLS  = 7'd64;
  localparam logic [23:0] RST_ROW_SCALE = 24'h010000;
  localparam logic [23:0] RST_COL_SCALE = 24'h010000;
  localparam logic        RST_ALIGN     = 1'b0;

  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic [6:0]  src_rows;
    logic [6:0]  src_cols;
    logic [23:0] row_scale;
    logic [23:0] col_scale;
    logic        round_en;
  } cfg_t;

  // control of one item handed from the address stage to the store
  typedef struct packed {
    logic vld;
    logic rd;
    logic hit;
  } op_t;

endpackage

@@ rtl/nrga_cfg.sv @@
// configuration registers behind the apb-style port
// depends on nrga_pkg
module nrga_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nrga_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output nrga_pkg::cfg_t                 cfg_o
);
  import nrga_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SRC_ROWS:  cfg_d.src_rows  = pwdata[6:0];
        REG_SRC_COLS:  cfg_d.src_cols  = pwdata[6:0];
        REG_ROW_SCALE: cfg_d.row_scale = pwdata[23:0];
        REG_COL_SCALE: cfg_d.col_scale = pwdata[23:0];
        REG_ALIGN:     cfg_d.round_en  = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_ROWS:  prdata = {25'd0, cfg_q.src_rows};
      REG_SRC_COLS:  prdata = {25'd0, cfg_q.src_cols};
      REG_ROW_SCALE: prdata = {8'd0, cfg_q.row_scale};
      REG_COL_SCALE: prdata = {8'd0, cfg_q.col_scale};
      REG_ALIGN:     prdata = {31'd0, cfg_q.round_en};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_rows  <= RST_SRC_ROWS;
      cfg_q.src_cols  <= RST_SRC_COLS;
      cfg_q.row_scale <= RST_ROW_SCALE;
      cfg_q.col_scale <= RST_COL_SCALE;
      cfg_q.round_en  <= RST_ALIGN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/nrga_map.sv @@
// coordinate mapping: input capture, scale multiply, round, clamp, store address
// depends on nrga_pkg
module nrga_map #(
  parameter int unsigned MAX_SRC_ROWS    = 64,
  parameter int unsigned MAX_SRC_COLS    = 64,
  parameter int unsigned MAX_CHANNELS    = 4,
  parameter int unsigned MAX_RESIZED_DIM = 256,
  localparam int unsigned DEPTH  = MAX_SRC_ROWS * MAX_SRC_COLS * MAX_CHANNELS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nrga_pkg::cfg_t       cfg_i,
  input  logic                 accept_i,
  input  logic                 func_i,
  input  logic [7:0]           row_i,
  input  logic [7:0]           col_i,
  input  logic [1:0]           channel_i,
  input  logic signed [31:0]   grad_value_i,
  output logic                 busy_o,
  output nrga_pkg::op_t        op_o,
  output logic [ADDR_W-1:0]    addr_o,
  output logic signed [31:0]   grad_o
);
  import nrga_pkg::*;

  // capture stage
  logic               in_vld_q;
  logic               func_q;
  logic [7:0]         row_q;
  logic [7:0]         col_q;
  logic [1:0]         ch_q;
  logic signed [31:0] grad_q;

  // product stage
  logic               p_vld_q;
  logic               p_func_q;
  logic [7:0]         p_row_q;
  logic [7:0]         p_col_q;
  logic [1:0]         p_ch_q;
  logic signed [31:0] p_grad_q;
  logic [31:0]        prod_r_q;
  logic [31:0]        prod_c_q;

  logic [10:0] rows_eff;
  logic [10:0] cols_eff;
  logic [32:0] rnd;
  logic [32:0] sum_r;
  logic [32:0] sum_c;
  logic [16:0] idx_r;
  logic [16:0] idx_c;
  logic [16:0] lim_r;
  logic [16:0] lim_c;
  logic [16:0] sel_r;
  logic [16:0] sel_c;
  logic [31:0] addr_full;
  logic        ch_ok;
  logic        acc_ok;
  logic        rd_ok;

  // size registers of zero act as one, above the maximum act as the maximum
  always_comb begin
    if (cfg_i.src_rows == 7'd0) begin
      rows_eff = 11'd1;
    end else if ({4'd0, cfg_i.src_rows} > 11'(MAX_SRC_ROWS)) begin
      rows_eff = 11'(MAX_SRC_ROWS);
    end else begin
      rows_eff = {4'd0, cfg_i.src_rows};
    end
    if (cfg_i.src_cols == 7'd0) begin
      cols_eff = 11'd1;
    end else if ({4'd0, cfg_i.src_cols} > 11'(MAX_SRC_COLS)) begin
      cols_eff = 11'(MAX_SRC_COLS);
    end else begin
      cols_eff = {4'd0, cfg_i.src_cols};
    end
  end

  always_comb begin
    rnd   = cfg_i.round_en ? 33'h0_0000_8000 : 33'd0;
    sum_r = {1'b0, prod_r_q} + rnd;
    sum_c = {1'b0, prod_c_q} + rnd;
    lim_r = {6'd0, rows_eff - 11'd1};
    lim_c = {6'd0, cols_eff - 11'd1};
    idx_r = (sum_r[32:16] > lim_r) ? lim_r : sum_r[32:16];
    idx_c = (sum_c[32:16] > lim_c) ? lim_c : sum_c[32:16];
    sel_r = (p_func_q == FUNC_READ) ? {9'd0, p_row_q} : idx_r;
    sel_c = (p_func_q == FUNC_READ) ? {9'd0, p_col_q} : idx_c;
    addr_full = (32'(sel_r) * 32'(MAX_SRC_COLS) + 32'(sel_c)) * 32'(MAX_CHANNELS)
                + 32'(p_ch_q);
    ch_ok  = {30'd0, p_ch_q} < 32'(MAX_CHANNELS);
    acc_ok = ch_ok && ({24'd0, p_row_q} < 32'(MAX_RESIZED_DIM))
                   && ({24'd0, p_col_q} < 32'(MAX_RESIZED_DIM));
    rd_ok  = ch_ok && ({3'd0, p_row_q} < rows_eff) && ({3'd0, p_col_q} < cols_eff);
  end

  assign op_o.vld = p_vld_q;
  assign op_o.rd  = (p_func_q == FUNC_READ);
  assign op_o.hit = (p_func_q == FUNC_READ) ? rd_ok : acc_ok;
  assign addr_o   = addr_full[ADDR_W-1:0];
  assign grad_o   = p_grad_q;
  assign busy_o   = in_vld_q | p_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      p_vld_q  <= 1'b0;
    end else begin
      in_vld_q <= accept_i;
      p_vld_q  <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      func_q <= func_i;
      row_q  <= row_i;
      col_q  <= col_i;
      ch_q   <= channel_i;
      grad_q <= grad_value_i;
    end
    if (in_vld_q) begin
      p_func_q <= func_q;
      p_row_q  <= row_q;
      p_col_q  <= col_q;
      p_ch_q   <= ch_q;
      p_grad_q <= grad_q;
      prod_r_q <= {24'd0, row_q} * {8'd0, cfg_i.row_scale};
      prod_c_q <= {24'd0, col_q} * {8'd0, cfg_i.col_scale};
    end
  end

endmodule

@@ rtl/nrga_store.sv @@
// gradient store: synchronous memory with clearing pass, read-modify-write
// with saturating add, read-and-clear and the result register
// depends on nrga_pkg
module nrga_store #(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nrga_pkg::op_t       op_i,
  input  logic [ADDR_W-1:0]   addr_i,
  input  logic signed [31:0]  grad_i,
  output logic                busy_o,
  output logic                dx_valid_o,
  output logic signed [31:0]  dx_value_o
);
  import nrga_pkg::*;

  logic [31:0] mem [DEPTH];

  logic              clearing_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  op_t               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic signed [31:0] grad_q;
  logic [31:0]       rdata_q;
  logic              dx_valid_q;
  logic signed [31:0] dx_value_q;
  logic signed [31:0] dx_value_d;

  logic [32:0]       sum;
  logic [31:0]       sat;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [31:0]       wd;

  always_comb begin
    sum = {rdata_q[31], rdata_q} + {grad_q[31], grad_q};
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = sum[31:0];
    end
    if (clearing_q) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = 32'd0;
    end else begin
      we = op_q.vld & op_q.hit;
      wa = addr_q;
      wd = op_q.rd ? 32'd0 : sat;
    end
    dx_value_d = op_q.hit ? rdata_q : 32'sd0;
  end

  assign busy_o     = clearing_q | op_q.vld;
  assign dx_valid_o = dx_valid_q;
  assign dx_value_o = dx_value_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (op_i.vld) begin
      rdata_q <= mem[addr_i];
      addr_q  <= addr_i;
      grad_q  <= grad_i;
    end
    if (op_q.vld && op_q.rd) begin
      dx_value_q <= dx_value_d;
    end
  end

  // one entry zeroed per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      op_q       <= '0;
      dx_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
        end
      end
      op_q       <= op_i;
      dx_valid_q <= op_q.vld & op_q.rd;
    end
  end

endmodule

@@ rtl/nearest_resize_grad_accumulate_top.sv @@
// Backward pass of a nearest-neighbour resize as a scatter-add into a gradient
// store of MAX_SRC_ROWS*MAX_SRC_COLS*MAX_CHANNELS entries. After reset the
// block holds busy high while it zeroes the store one entry a cycle. An item
// is taken when start is high and busy is low; each item then passes through
// capture, scale multiply, address and memory read, and the write-back through
// the single store port before the next can be taken. A read item gives its
// result on dx_value_o with dx_valid_o high for one cycle, after the capture,
// product, store operation and result registers; the receiver cannot stall it.
// An accumulate gives no result. The user must write configuration registers
// only while idle; the block does not enforce it.
// top level: ties config, mapping and store together; depends on nrga_pkg
module nearest_resize_grad_accumulate_top #(
  parameter int unsigned MAX_SRC_ROWS    = 64,
  parameter int unsigned MAX_SRC_COLS    = 64,
  parameter int unsigned MAX_CHANNELS    = 4,
  parameter int unsigned MAX_RESIZED_DIM = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nrga_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func_i,
  input  logic [7:0]                     row_i,
  input  logic [7:0]                     col_i,
  input  logic [1:0]                     channel_i,
  input  logic signed [31:0]             grad_value_i,
  output logic                           dx_valid_o,
  output logic signed [31:0]             dx_value_o
);
  import nrga_pkg::*;

  localparam int unsigned DEPTH  = MAX_SRC_ROWS * MAX_SRC_COLS * MAX_CHANNELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t               cfg;
  op_t                op;
  logic [ADDR_W-1:0]  addr;
  logic signed [31:0] grad;
  logic               accept;
  logic               map_busy;
  logic               store_busy;

  assign busy   = map_busy | store_busy;
  assign accept = start & ~busy;

  nrga_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nrga_map #(
    .MAX_SRC_ROWS    (MAX_SRC_ROWS),
    .MAX_SRC_COLS    (MAX_SRC_COLS),
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_RESIZED_DIM (MAX_RESIZED_DIM)
  ) u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .func_i       (func_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .channel_i    (channel_i),
    .grad_value_i (grad_value_i),
    .busy_o       (map_busy),
    .op_o         (op),
    .addr_o       (addr),
    .grad_o       (grad)
  );

  nrga_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .addr_i     (addr),
    .grad_i     (grad),
    .busy_o     (store_busy),
    .dx_valid_o (dx_valid_o),
    .dx_value_o (dx_value_o)
  );

endmodule
